// ===== rtl/core/src_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the soil retention
// curve evaluator. No dependencies.
`default_nettype none
package src_pkg;

  localparam int PW = 64;                     // product width before the constant divide
  localparam int LW = 48;                     // log-domain values, signed Q16.32
  localparam int PRESSURE_FRAC_BITS_DEF = 8;

  localparam int LOG_LAT = 33;
  localparam int DIV_LAT = 10;
  localparam int EXP_LAT = 33;

  localparam logic [13:0] DIVISOR = 14'd10000;
  localparam logic [18:0] DIV_RECIP = 19'd429496;    // floor(2^32 / 10000)

  localparam logic signed [15:0] K_U = 16'sd24279;
  localparam logic signed [15:0] K_D = 16'sd14279;
  localparam logic signed [15:0] K_K = 16'sd9529;
  localparam logic signed [15:0] K_Q = -16'sd471;

  typedef logic [31:0] root_tab_t [0:30];

  function automatic logic [63:0] log2q_c(input logic [63:0] x);
    int p;
    logic [63:0] m;
    logic [31:0] fr;
    p = 63;
    fr = '0;
    while (x[p] == 1'b0 && p > 0) p--;
    if (p >= 31) m = x >> (p - 31);
    else m = x << (31 - p);
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m[32]) begin
        m = m >> 1;
        fr[i] = 1'b1;
      end
    end
    return {p[31:0], fr};
  endfunction

  function automatic logic [63:0] isqrt_c(input logic [63:0] xi);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = xi;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Successive square roots of two in Q.31, floored at each step.
  function automatic root_tab_t exp_root_tab();
    root_tab_t tab;
    logic [63:0] root;
    root = isqrt_c(64'd1 << 63);
    for (int i = 0; i < 31; i++) begin
      tab[i] = root[31:0];
      root = isqrt_c(root << 31);
    end
    return tab;
  endfunction

  // log2(mant) - dec * log2(10), Q.32.
  function automatic logic signed [63:0] lconst(input logic [63:0] mant, input int dec);
    logic signed [63:0] l10;
    l10 = $signed(log2q_c(64'd10));
    return $signed(log2q_c(mant)) - $signed(64'(dec)) * l10;
  endfunction

  localparam root_tab_t EXP_ROOT = exp_root_tab();

  localparam logic signed [63:0] C_U64 = lconst(64'd19722, 15);
  localparam logic signed [63:0] C_D64 = lconst(64'd47883044, 18);
  localparam logic signed [63:0] C_K64 = lconst(64'd2207, 3);
  localparam logic signed [63:0] C_Q64 = lconst(64'd21030503, 7);
  localparam logic signed [LW-1:0] C_U = C_U64[LW-1:0];
  localparam logic signed [LW-1:0] C_D = C_D64[LW-1:0];
  localparam logic signed [LW-1:0] C_K = C_K64[LW-1:0];
  localparam logic signed [LW-1:0] C_Q = C_Q64[LW-1:0];

  localparam logic [40:0] CAP_FRAC = 41'h100_0000_0000;
  localparam logic [40:0] CAP_SLOPE = 41'h0FF_FFFF_FFFF;

endpackage
`default_nettype wire

// ===== rtl/core/src_log2.sv =====
// Pipelined base-2 logarithm of a positive 32-bit integer, result Q.32.
// One normalize stage, then one squaring stage per fraction bit. Uses src_pkg.
`default_nettype none
module src_log2 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] x,
  output logic [36:0]      y
);
  import src_pkg::*;

  logic [31:0] m_r   [0:32];
  logic [4:0]  p_r   [0:32];
  logic [31:0] fr_r  [0:32];
  logic [31:0] m_nxt [0:32];
  logic [31:0] fr_nxt [0:32];
  logic [4:0]  p0;
  logic [63:0] sq;

  always_comb begin
    p0 = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p0 = 5'(i);
    end
    m_nxt[0] = x << (5'd31 - p0);
    fr_nxt[0] = '0;
    sq = '0;
    for (int j = 1; j <= 32; j++) begin
      sq = 64'(m_r[j-1]) * 64'(m_r[j-1]);
      fr_nxt[j] = fr_r[j-1];
      if (sq[63]) begin
        m_nxt[j] = sq[63:32];
        fr_nxt[j][32-j] = 1'b1;
      end else begin
        m_nxt[j] = sq[62:31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m_nxt[0];
      p_r[0] <= p0;
      fr_r[0] <= fr_nxt[0];
      for (int j = 1; j <= 32; j++) begin
        m_r[j] <= m_nxt[j];
        p_r[j] <= p_r[j-1];
        fr_r[j] <= fr_nxt[j];
      end
    end
  end

  assign y = {p_r[32], fr_r[32]};

endmodule
`default_nettype wire

// ===== rtl/core/src_cdiv.sv =====
// Pipelined signed divide by ten thousand with truncation toward zero.
// One byte of the magnitude per stage through a reciprocal multiply. Uses src_pkg.
`default_nettype none
module src_cdiv (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [src_pkg::PW-1:0] x,
  output logic signed [src_pkg::LW-1:0]    y
);
  import src_pkg::*;

  localparam int NSTEP = PW / 8;

  logic [PW-1:0] mag_r   [0:NSTEP];
  logic [PW-1:0] q_r     [0:NSTEP];
  logic [13:0]   rem_r   [0:NSTEP];
  logic          neg_r   [0:NSTEP];
  logic [PW-1:0] q_nxt   [1:NSTEP];
  logic [13:0]   rem_nxt [1:NSTEP];
  logic [21:0]   v;
  logic [40:0]   prod;
  logic [7:0]    qd;
  logic [21:0]   rm;
  logic signed [LW-1:0] y_r;

  always_comb begin
    v = '0;
    prod = '0;
    qd = '0;
    rm = '0;
    for (int j = 1; j <= NSTEP; j++) begin
      v = {rem_r[j-1], mag_r[j-1][PW-1 -: 8]};
      prod = 41'(v) * 41'(DIV_RECIP);
      qd = prod[39:32];
      rm = v - 22'(qd) * 22'(DIVISOR);
      // The reciprocal is floored, so the digit can be one short.
      if (rm >= 22'(DIVISOR)) begin
        qd = qd + 8'd1;
        rm = rm - 22'(DIVISOR);
      end
      q_nxt[j] = {q_r[j-1][PW-9:0], qd};
      rem_nxt[j] = rm[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= x[PW-1];
      mag_r[0] <= x[PW-1] ? PW'(-x) : PW'(x);
      q_r[0] <= '0;
      rem_r[0] <= '0;
      for (int j = 1; j <= NSTEP; j++) begin
        neg_r[j] <= neg_r[j-1];
        mag_r[j] <= mag_r[j-1] << 8;
        q_r[j] <= q_nxt[j];
        rem_r[j] <= rem_nxt[j];
      end
      y_r <= neg_r[NSTEP] ? LW'(-q_r[NSTEP]) : LW'(q_r[NSTEP]);
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/core/src_exp2.sv =====
// Pipelined power of two of a Q.32 log-domain value with offset, rounding and cap.
// One root multiply per fraction bit but the lowest, then a final rounding shift. Uses src_pkg.
`default_nettype none
module src_exp2 #(
  parameter int          OFS = 30,
  parameter logic [40:0] CAP = src_pkg::CAP_FRAC
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [src_pkg::LW-1:0] x,
  output logic [40:0]                      y
);
  import src_pkg::*;

  localparam int NW = LW - 32;

  logic [32:0]          m_r   [0:31];
  logic [31:0]          f_r   [0:31];
  logic signed [NW-1:0] n_r   [0:31];
  logic [32:0]          m_nxt [1:31];
  logic signed [LW-1:0] t;
  logic [63:0]          pr;
  logic signed [NW:0]   k;
  logic [NW:0]          sh;
  logic [63:0]          v;
  logic [40:0]          y_r;

  assign t = x + (LW'(OFS) <<< 32);

  always_comb begin
    pr = '0;
    for (int i = 1; i <= 31; i++) begin
      pr = 64'(m_r[i-1]) * 64'(EXP_ROOT[i-1]) + (64'd1 << 30);
      if (f_r[i-1][32-i]) m_nxt[i] = pr[63:31];
      else m_nxt[i] = m_r[i-1];
    end
  end

  always_comb begin
    k = (NW+1)'(n_r[31]) - (NW+1)'(31);
    sh = '0;
    v = '0;
    if (!k[NW]) begin
      if (k >= (NW+1)'(31)) v = 64'(CAP);
      else v = 64'(m_r[31]) << k[4:0];
    end else begin
      sh = (NW+1)'(-k);
      if (sh >= (NW+1)'(64)) v = '0;
      else v = (64'(m_r[31]) + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
    end
    if (v > 64'(CAP)) v = 64'(CAP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= 33'd1 << 31;
      f_r[0] <= t[31:0];
      n_r[0] <= t[LW-1:32];
      for (int i = 1; i <= 31; i++) begin
        m_r[i] <= m_nxt[i];
        f_r[i] <= f_r[i-1];
        n_r[i] <= n_r[i-1];
      end
      y_r <= v[40:0];
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/core/soil_retention_curve_eval.sv =====
// Soil retention curve evaluator: for each item of liquid and gas pressure it returns
// saturation, relative permeability and their slopes by liquid pressure, worked in the
// log domain. The pipeline takes one item every cycle unless it is held, and its depth
// comes from the 32 squaring stages of the logarithm, two divide-by-constant pipelines
// and the 31 root-multiply stages of the power units. When the output is stalled with
// a result waiting, the whole pipeline holds.
`default_nettype none
module soil_retention_curve_eval #(
  parameter int PRESSURE_FRAC_BITS = src_pkg::PRESSURE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_liquid_pressure,
  input  wire logic signed [31:0] in_gas_pressure,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_saturation,
  output logic [39:0]             out_saturation_slope,
  output logic signed [31:0]      out_rel_permeability,
  output logic [39:0]             out_permeability_slope
);
  import src_pkg::*;

  localparam int MID = LOG_LAT + 1 + DIV_LAT + 1 + 1 + DIV_LAT + 1 + EXP_LAT;
  localparam int DLY = DIV_LAT + 1;
  localparam logic signed [LW-1:0] FB_Q = LW'(PRESSURE_FRAC_BITS) <<< 32;

  logic en;
  logic signed [32:0] s;
  logic nonpos;
  logic [31:0] s_r;
  logic vld_r [0:MID];
  logic np_r  [0:MID];
  logic [36:0] log_y;
  logic signed [LW-1:0] ls;
  logic signed [PW-1:0] pu_r, pd_r, pk_r, pq_r;
  logic signed [LW-1:0] qu, qd, qk, qq;
  logic signed [LW-1:0] lu_r, ld_r;
  logic signed [LW-1:0] lu_dly_r [0:DLY-1];
  logic signed [LW-1:0] ld_dly_r [0:DLY-1];
  logic signed [LW-1:0] lu_a_r, ld_a_r, lk_a_r, lq_a_r;
  logic [40:0] eu, ed, ek, eq;
  logic signed [42:0] sat_v, krf_v;
  logic signed [31:0] sat_nxt, krf_nxt;
  logic out_valid_r;
  logic signed [31:0] sat_r, krf_r;
  logic [39:0] dsat_r, dkrf_r;

  assign en = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign s = 33'(in_gas_pressure) - 33'(in_liquid_pressure);
  assign nonpos = s[32] || (s == 33'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MID; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= MID; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[MID];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= nonpos ? 32'd1 : s[31:0];
      np_r[0] <= nonpos;
      for (int i = 1; i <= MID; i++) np_r[i] <= np_r[i-1];
    end
  end

  src_log2 u_log (.clk(clk), .en(en), .x(s_r), .y(log_y));

  assign ls = $signed(LW'(log_y)) - FB_Q;

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r <= PW'(ls) * PW'(K_U);
      pd_r <= PW'(ls) * PW'(K_D);
      lu_r <= qu + C_U;
      ld_r <= qd + C_D;
      pk_r <= PW'(lu_r) * PW'(K_K);
      pq_r <= PW'(lu_r) * PW'(K_Q);
      lu_dly_r[0] <= lu_r;
      ld_dly_r[0] <= ld_r;
      for (int i = 1; i < DLY; i++) begin
        lu_dly_r[i] <= lu_dly_r[i-1];
        ld_dly_r[i] <= ld_dly_r[i-1];
      end
      lu_a_r <= lu_dly_r[DLY-1];
      ld_a_r <= ld_dly_r[DLY-1];
      lk_a_r <= qk + C_K;
      lq_a_r <= qq + C_Q + ld_dly_r[DLY-1];
    end
  end

  src_cdiv u_div_u (.clk(clk), .en(en), .x(pu_r), .y(qu));
  src_cdiv u_div_d (.clk(clk), .en(en), .x(pd_r), .y(qd));
  src_cdiv u_div_k (.clk(clk), .en(en), .x(pk_r), .y(qk));
  src_cdiv u_div_q (.clk(clk), .en(en), .x(pq_r), .y(qq));

  src_exp2 #(.OFS(30), .CAP(CAP_FRAC))  u_exp_u (.clk(clk), .en(en), .x(lu_a_r), .y(eu));
  src_exp2 #(.OFS(48), .CAP(CAP_SLOPE)) u_exp_d (.clk(clk), .en(en), .x(ld_a_r), .y(ed));
  src_exp2 #(.OFS(30), .CAP(CAP_FRAC))  u_exp_k (.clk(clk), .en(en), .x(lk_a_r), .y(ek));
  src_exp2 #(.OFS(48), .CAP(CAP_SLOPE)) u_exp_q (.clk(clk), .en(en), .x(lq_a_r), .y(eq));

  // The fractions are one minus the drop, clamped at minus two.
  always_comb begin
    sat_v = (43'sd1 <<< 30) - $signed(43'(eu));
    krf_v = (43'sd1 <<< 30) - $signed(43'(ek));
    sat_nxt = (sat_v < -(43'sd1 <<< 31)) ? 32'sh8000_0000 : sat_v[31:0];
    krf_nxt = (krf_v < -(43'sd1 <<< 31)) ? 32'sh8000_0000 : krf_v[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (np_r[MID]) begin
        sat_r <= 32'sd1 <<< 30;
        krf_r <= 32'sd1 <<< 30;
        dsat_r <= '0;
        dkrf_r <= '0;
      end else begin
        sat_r <= sat_nxt;
        krf_r <= krf_nxt;
        dsat_r <= ed[39:0];
        dkrf_r <= eq[39:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_saturation = sat_r;
  assign out_saturation_slope = dsat_r;
  assign out_rel_permeability = krf_r;
  assign out_permeability_slope = dkrf_r;

endmodule
`default_nettype wire
